/* rtl/core/bsfs_pkg.sv */
// ----------------------------------------------------------------------------
// bsfs_pkg
// Shared types and constants of the buffered serial frame shifter.
// ----------------------------------------------------------------------------
package bsfs_pkg;

   // request command codes
   localparam logic [2:0] CMD_WRITE  = 3'd0;
   localparam logic [2:0] CMD_LOCK   = 3'd1;
   localparam logic [2:0] CMD_UNLOCK = 3'd2;
   localparam logic [2:0] CMD_SEND   = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam int         FRAME_W  = 36;
   localparam logic [5:0] LAST_BIT = 6'd35;
   localparam logic [7:0] LOCK_MAX = 8'hFF;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_LOCK,
      OP_UNLOCK,
      OP_SEND,
      OP_TICK
   } op_type;

   // half-bit slot sequence of one frame
   typedef enum logic [3:0] {
      PH_DRIVE   = 4'b0001,
      PH_RISE    = 4'b0010,
      PH_UNLATCH = 4'b0100,
      PH_GAP     = 4'b1000
   } phase_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  code;
      logic [31:0] payload;
   } item_type;

endpackage

/* rtl/core/bsfs_ram.sv */
// ----------------------------------------------------------------------------
// bsfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsfs_ram #(
   parameter  int WIDTH  = 36,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bsfs_front.sv */
// ----------------------------------------------------------------------------
// bsfs_front
// Takes requests, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bsfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [3:0]         req_code,
   input  logic [31:0]        req_payload,
   output logic               item_valid,
   input  logic               item_pop,
   output bsfs_pkg::item_type item
);
   import bsfs_pkg::*;

   item_type   slot_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       tail;
   item_type   decoded;

   always_comb begin
      decoded.code    = req_code;
      decoded.payload = req_payload;
      unique case (req_cmd)
         CMD_WRITE:  decoded.op = OP_WRITE;
         CMD_LOCK:   decoded.op = OP_LOCK;
         CMD_UNLOCK: decoded.op = OP_UNLOCK;
         CMD_SEND:   decoded.op = OP_SEND;
         CMD_TICK:   decoded.op = OP_TICK;
         default:    decoded.op = OP_NONE;
      endcase
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[head_ff];
   assign tail       = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (item_pop) begin
         head_in = ~head_ff;
      end
      case ({push, item_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail] <= decoded;
      end
   end

endmodule

/* rtl/core/bsfs_back.sv */
// ----------------------------------------------------------------------------
// bsfs_back
// Executes queued requests: message store, lock count, frame shifter and
// the registered response slot.
// ----------------------------------------------------------------------------
module bsfs_back #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_pop,
   input  bsfs_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_busy_res,
   output logic [4:0]         rsp_fill,
   output logic               rsp_clk_pin,
   output logic               rsp_data_pin,
   output logic               rsp_latch_pin
);
   import bsfs_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0] frame_next;
   logic [7:0]       lock_ff, lock_in;
   logic             sending_ff, sending_in;
   logic [5:0]       bit_ff, bit_in;
   logic [5:0]       bit_next;
   phase_type        phase_ff, phase_in;
   logic             clk_ff, clk_in;
   logic             data_ff, data_in;
   logic             latch_ff, latch_in;
   logic             accepted;
   logic             wr_en;
   logic [FRAME_W-1:0] rd_data;

   logic       rsp_valid_ff;
   logic       rsp_accepted_ff;
   logic       rsp_busy_ff;
   logic [4:0] rsp_fill_ff;
   logic       rsp_clk_ff, rsp_data_ff, rsp_latch_ff;

   assign item_pop   = item_valid && (!rsp_valid_ff || rsp_ready);
   assign frame_next = frame_ff + CNT_W'(1);
   assign bit_next   = bit_ff + 6'd1;

   always_comb begin
      fill_in    = fill_ff;
      frame_in   = frame_ff;
      lock_in    = lock_ff;
      sending_in = sending_ff;
      bit_in     = bit_ff;
      phase_in   = phase_ff;
      clk_in     = clk_ff;
      data_in    = data_ff;
      latch_in   = latch_ff;
      accepted   = 1'b0;
      wr_en      = 1'b0;
      if (item_pop) begin
         unique case (item.op)
            OP_WRITE: begin
               if (!sending_ff && fill_ff < CNT_W'(DEPTH) && lock_ff == 8'd0) begin
                  wr_en    = 1'b1;
                  accepted = 1'b1;
                  fill_in  = fill_ff + CNT_W'(1);
               end
            end
            OP_LOCK: begin
               if (lock_ff != LOCK_MAX) lock_in = lock_ff + 8'd1;
            end
            OP_UNLOCK: begin
               if (lock_ff != 8'd0) lock_in = lock_ff - 8'd1;
            end
            OP_SEND: begin
               if (!sending_ff && fill_ff != '0) begin
                  sending_in = 1'b1;
                  frame_in   = '0;
                  bit_in     = 6'd0;
                  phase_in   = PH_DRIVE;
               end
            end
            OP_TICK: begin
               if (sending_ff) begin
                  unique case (phase_ff)
                     PH_DRIVE: begin
                        clk_in   = 1'b0;
                        data_in  = rd_data[LAST_BIT - bit_ff];
                        latch_in = 1'b1;
                        phase_in = PH_RISE;
                     end
                     PH_RISE: begin
                        clk_in   = 1'b1;
                        bit_in   = bit_next;
                        phase_in = (bit_next > LAST_BIT) ? PH_UNLATCH : PH_DRIVE;
                     end
                     PH_UNLATCH: begin
                        latch_in = 1'b0;
                        phase_in = PH_GAP;
                     end
                     PH_GAP: begin
                        bit_in   = 6'd0;
                        frame_in = frame_next;
                        phase_in = PH_DRIVE;
                        if (frame_next >= fill_ff) begin
                           sending_in = 1'b0;
                           frame_in   = '0;
                           fill_in    = '0;
                        end
                     end
                     default: phase_in = PH_DRIVE;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // read address follows the next frame index so the data is ready on the
   // first drive slot of each frame
   bsfs_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data ({item.code, item.payload}),
      .rd_addr (frame_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         frame_ff     <= '0;
         lock_ff      <= 8'd0;
         sending_ff   <= 1'b0;
         bit_ff       <= 6'd0;
         phase_ff     <= PH_DRIVE;
         clk_ff       <= 1'b0;
         data_ff      <= 1'b0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         frame_ff   <= frame_in;
         lock_ff    <= lock_in;
         sending_ff <= sending_in;
         bit_ff     <= bit_in;
         phase_ff   <= phase_in;
         clk_ff     <= clk_in;
         data_ff    <= data_in;
         latch_ff   <= latch_in;
         if (item_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (item_pop) begin
         rsp_accepted_ff <= accepted;
         rsp_busy_ff     <= sending_in;
         rsp_fill_ff     <= 5'(fill_in);
         rsp_clk_ff      <= clk_in;
         rsp_data_ff     <= data_in;
         rsp_latch_ff    <= latch_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_clk_pin   = rsp_clk_ff;
   assign rsp_data_pin  = rsp_data_ff;
   assign rsp_latch_pin = rsp_latch_ff;

endmodule

/* rtl/core/buffered_serial_frame_shifter.sv */
// ----------------------------------------------------------------------------
// buffered_serial_frame_shifter
// Message buffer with lock count and a tick-driven 36-bit serial frame
// shifter (clock, data, latch lines).
// ----------------------------------------------------------------------------
//   channel  | ports   | carries
//   ---------+---------+--------------------------------------------------
//   request  | req_*   | cmd, code, payload
//   response | rsp_*   | accepted, busy_res, fill, clk/data/latch pin levels
//
// One request per clock is taken while the response side is not stalled,
// and one response per request is given. A response follows its request
// through the two-entry decode queue and the response register: the request
// is held in the queue, is executed as it leaves it, and its result lands
// in the response register. Each tick command is one slot of the shifter.
// Reset clears the counters, shifter state and both handshakes; the message
// store is not cleared. A stalled response stops the execute stage, and the
// queue keeps taking requests until both entries are full.
// ----------------------------------------------------------------------------
module buffered_serial_frame_shifter #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_code,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_busy_res,
   output logic [4:0]  rsp_fill,
   output logic        rsp_clk_pin,
   output logic        rsp_data_pin,
   output logic        rsp_latch_pin
);
   import bsfs_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_pop;

   bsfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_code    (req_code),
      .req_payload (req_payload),
      .item_valid  (item_valid),
      .item_pop    (item_pop),
      .item        (item)
   );

   bsfs_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_pop      (item_pop),
      .item          (item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accepted  (rsp_accepted),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_fill      (rsp_fill),
      .rsp_clk_pin   (rsp_clk_pin),
      .rsp_data_pin  (rsp_data_pin),
      .rsp_latch_pin (rsp_latch_pin)
   );

endmodule

/* rtl/core/bsfs_checker.sv */
// ----------------------------------------------------------------------------
// bsfs_checker
// Port-level checks of the buffered serial frame shifter.
// ----------------------------------------------------------------------------
module bsfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_busy_res,
   input logic [4:0]  rsp_fill,
   input logic        rsp_clk_pin,
   input logic        rsp_data_pin,
   input logic        rsp_latch_pin
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_busy_res) && $stable(rsp_fill) && $stable(rsp_clk_pin)
         && $stable(rsp_data_pin) && $stable(rsp_latch_pin))
      else $error("response changed while stalled");

   // a stored write never starts a flush
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_busy_res)
      else $error("write stored while flushing");

   // latch only high inside a flush
   a_latch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch_pin |-> rsp_busy_res)
      else $error("latch high outside a flush");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind buffered_serial_frame_shifter bsfs_checker u_bsfs_checker (.*);

/* tb/sv/buffered_serial_frame_shifter_tb.sv */
// ----------------------------------------------------------------------------
// buffered_serial_frame_shifter_tb
// Drives command streams (writes, lock/unlock, send, ticks) into the frame
// shifter, tracks buffer, lock count and line levels in a local shadow of the
// block, and checks every response in order against it. Random idling on both
// channels in the first two of three stretches; the sender drains between them.
// ----------------------------------------------------------------------------
module buffered_serial_frame_shifter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsfs_pkg::*;

   localparam int DEPTH           = 16;
   localparam int SLOTS_PER_FRAME = 2 * FRAME_W + 2;
   localparam int LIMIT           = 200000;
   localparam int TAIL_CYCLES     = 8;

   // command values the block does not decode
   localparam logic [2:0] CMD_RSVD_LO = 3'd5;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [3:0]  code;
      logic [31:0] word;
   } req_t;

   typedef struct {
      logic       accepted;
      logic       busy;
      logic [4:0] fill;
      logic       clk;
      logic       data;
      logic       latch;
   } rsp_t;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd     = CMD_TICK;
   logic [3:0]  req_code    = 4'd0;
   logic [31:0] req_payload = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_accepted;
   logic        rsp_busy_res;
   logic [4:0]  rsp_fill;
   logic        rsp_clk_pin;
   logic        rsp_data_pin;
   logic        rsp_latch_pin;

   req_t req_backlog[$];
   rsp_t rsp_awaited[$];

   int send_idle_pct = 29;
   int recv_idle_pct = 58;
   int mismatches    = 0;
   int cycles        = 0;
   int rsp_seen      = 0;
   int pushed        = 0;
   int owed_ticks    = 0;

   // shadow of the block state
   logic [3:0]  code_mem [DEPTH];
   logic [31:0] word_mem [DEPTH];
   int          fill_cnt   = 0;
   logic [7:0]  lock_cnt   = 8'd0;
   logic        flushing   = 1'b0;
   int          frame_no   = 0;
   int          bit_no     = 0;
   phase_type   slot       = PH_DRIVE;
   logic        clk_line   = 1'b0;
   logic        data_line  = 1'b0;
   logic        latch_line = 1'b0;

   buffered_serial_frame_shifter #(.DEPTH(DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_code     (req_code),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_busy_res (rsp_busy_res),
      .rsp_fill     (rsp_fill),
      .rsp_clk_pin  (rsp_clk_pin),
      .rsp_data_pin (rsp_data_pin),
      .rsp_latch_pin(rsp_latch_pin)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one request to the shadow state and returns the line levels after it
   function automatic rsp_t step_shifter(input logic [2:0] cmd, input logic [3:0] code,
                                         input logic [31:0] word);
      rsp_t        r;
      logic [35:0] frame;
      r.accepted = 1'b0;
      case (cmd)
         CMD_WRITE: begin
            if (!flushing && fill_cnt < DEPTH && lock_cnt == 8'd0) begin
               code_mem[fill_cnt] = code;
               word_mem[fill_cnt] = word;
               fill_cnt++;
               r.accepted = 1'b1;
            end
         end
         CMD_LOCK: begin
            if (lock_cnt != LOCK_MAX) lock_cnt++;
         end
         CMD_UNLOCK: begin
            if (lock_cnt != 8'd0) lock_cnt--;
         end
         CMD_SEND: begin
            if (!flushing && fill_cnt != 0) begin
               flushing = 1'b1;
               frame_no = 0;
               bit_no   = 0;
               slot     = PH_DRIVE;
            end
         end
         CMD_TICK: begin
            if (flushing) begin
               case (slot)
                  PH_DRIVE: begin
                     frame      = {code_mem[frame_no], word_mem[frame_no]};
                     clk_line   = 1'b0;
                     data_line  = frame[FRAME_W - 1 - bit_no];
                     latch_line = 1'b1;
                     slot       = PH_RISE;
                  end
                  PH_RISE: begin
                     clk_line = 1'b1;
                     bit_no++;
                     slot = (bit_no >= FRAME_W) ? PH_UNLATCH : PH_DRIVE;
                  end
                  PH_UNLATCH: begin
                     latch_line = 1'b0;
                     slot       = PH_GAP;
                  end
                  default: begin
                     bit_no = 0;
                     frame_no++;
                     slot = PH_DRIVE;
                     if (frame_no >= fill_cnt) begin
                        flushing = 1'b0;
                        frame_no = 0;
                        fill_cnt = 0;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
      r.busy  = flushing;
      r.fill  = fill_cnt[4:0];
      r.clk   = clk_line;
      r.data  = data_line;
      r.latch = latch_line;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch %0d: %s", mismatches, what);
   endtask

   task automatic push_item(input logic [2:0] cmd, input logic [3:0] code,
                            input logic [31:0] word);
      req_backlog.push_back('{cmd, code, word});
      pushed++;
   endtask

   function automatic logic [3:0] pick_code();
      return 4'($urandom_range(15));
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // stray or out-of-place requests; locks always come back down
   task automatic push_noise();
      case ($urandom_range(5))
         0: begin
            push_item(CMD_LOCK, pick_code(), $urandom);
            push_item(CMD_WRITE, pick_code(), pick_word());
            push_item(CMD_UNLOCK, pick_code(), $urandom);
         end
         1: push_item(CMD_UNLOCK, pick_code(), $urandom);
         2: push_item(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), pick_code(), $urandom);
         3: push_item(CMD_WRITE, pick_code(), pick_word());
         4: push_item(CMD_SEND, pick_code(), $urandom);
         default: push_item(CMD_TICK, pick_code(), $urandom);
      endcase
   endtask

   // n writes, a send, and enough ticks to shift them out (cut short if broken)
   task automatic add_flush_seq(input int n, input bit broken);
      int ticks;
      int k;
      for (k = 0; k < n; k++) begin
         push_item(CMD_WRITE, pick_code(), pick_word());
         if ($urandom_range(9) == 0) push_noise();
      end
      push_item(CMD_SEND, pick_code(), $urandom);
      ticks = n * SLOTS_PER_FRAME;
      if (broken) begin
         k = $urandom_range(ticks);
         owed_ticks += ticks - k;
         ticks = k;
      end
      for (k = 0; k < ticks; k++) begin
         push_item(CMD_TICK, pick_code(), $urandom);
         if ($urandom_range(19) == 0) push_noise();
      end
   endtask

   task automatic add_random_phase(input int budget);
      int stop;
      int n;
      stop = pushed + budget;
      while (pushed < stop) begin
         case ($urandom_range(9))
            0:       n = 0;
            1:       n = 2;
            default: n = 1;
         endcase
         add_flush_seq(n, $urandom_range(9) == 0);
      end
      // make up for flushes that were cut short so the next stretch starts idle
      if (owed_ticks > DEPTH * SLOTS_PER_FRAME) owed_ticks = DEPTH * SLOTS_PER_FRAME;
      repeat (owed_ticks) push_item(CMD_TICK, pick_code(), $urandom);
      owed_ticks = 0;
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || rsp_awaited.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      req_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            rsp_awaited.push_back(step_shifter(req_cmd, req_code, req_payload));
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = req_backlog.pop_front();
               req_valid   <= 1'b1;
               req_cmd     <= nxt.cmd;
               req_code    <= nxt.code;
               req_payload <= nxt.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (rsp_awaited.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request pending", rsp_seen));
            end else begin
               want = rsp_awaited.pop_front();
               if (rsp_accepted !== want.accepted || rsp_busy_res !== want.busy ||
                   rsp_fill !== want.fill || rsp_clk_pin !== want.clk ||
                   rsp_data_pin !== want.data || rsp_latch_pin !== want.latch)
                  report_mismatch($sformatf(
                     "response %0d got %b %b %0d %b %b %b, want %b %b %0d %b %b %b",
                     rsp_seen, rsp_accepted, rsp_busy_res, rsp_fill, rsp_clk_pin,
                     rsp_data_pin, rsp_latch_pin, want.accepted, want.busy, want.fill,
                     want.clk, want.data, want.latch));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle corner cases: tick, empty send, unlock at zero, undecoded commands
      push_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF);
      push_item(CMD_SEND, 4'h0, 32'h0);
      push_item(CMD_UNLOCK, 4'h0, 32'h0);
      push_item(CMD_RSVD_LO, 4'h5, 32'h1234_5678);
      push_item(CMD_RSVD_LO + 3'd1, 4'hA, 32'h8765_4321);
      push_item(CMD_RSVD_HI, 4'hF, 32'hFFFF_FFFF);
      // field extremes, then a write under lock
      push_item(CMD_WRITE, 4'hF, 32'hFFFF_FFFF);
      push_item(CMD_LOCK, 4'h0, 32'h0);
      push_item(CMD_WRITE, 4'h3, 32'hDEAD_0001);
      push_item(CMD_UNLOCK, 4'h0, 32'h0);
      push_item(CMD_WRITE, 4'hA, 32'hA5A5_5A5A);
      push_item(CMD_SEND, 4'h0, 32'h0);
      // while busy: write and send ignored, lock/unlock still count
      push_item(CMD_WRITE, 4'h6, 32'h0F0F_F0F0);
      push_item(CMD_SEND, 4'h0, 32'h0);
      push_item(CMD_LOCK, 4'h0, 32'h0);
      push_item(CMD_UNLOCK, 4'h0, 32'h0);
      for (k = 0; k < 2 * SLOTS_PER_FRAME; k++)
         push_item(CMD_TICK, pick_code(), $urandom);
      add_random_phase(40);
      wait_drained();

      @(negedge clock);
      send_idle_pct = 58;
      recv_idle_pct = 29;
      // lock count stacks, floors at zero, and blocks writes until fully released
      push_item(CMD_LOCK, pick_code(), $urandom);
      push_item(CMD_LOCK, pick_code(), $urandom);
      push_item(CMD_WRITE, pick_code(), pick_word());
      push_item(CMD_UNLOCK, pick_code(), $urandom);
      push_item(CMD_WRITE, pick_code(), pick_word());
      push_item(CMD_UNLOCK, pick_code(), $urandom);
      push_item(CMD_UNLOCK, pick_code(), $urandom);
      push_item(CMD_WRITE, pick_code(), pick_word());
      owed_ticks += SLOTS_PER_FRAME;
      add_random_phase(40);
      wait_drained();

      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // fill the buffer, one write past full, then shift the first frame out
      for (k = 0; k <= DEPTH; k++) push_item(CMD_WRITE, pick_code(), pick_word());
      push_item(CMD_SEND, pick_code(), $urandom);
      for (k = 0; k < SLOTS_PER_FRAME; k++)
         push_item(CMD_TICK, pick_code(), $urandom);
      push_item(CMD_WRITE, pick_code(), pick_word());
      push_item(CMD_SEND, pick_code(), $urandom);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_awaited.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", rsp_awaited.size()));
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/bsfs_pkg.sv
rtl/core/bsfs_ram.sv
rtl/core/bsfs_front.sv
rtl/core/bsfs_back.sv
rtl/core/buffered_serial_frame_shifter.sv
rtl/core/bsfs_checker.sv
tb/sv/buffered_serial_frame_shifter_tb.sv
